>>> sv/ithp_pkg.sv
// Shared types and constants for the IPv4/TCP header parser.
// Holds the field codes, the result record and the result queue sizing.
// Used by ithp_parse, ithp_res_fifo and ipv4_tcp_header_parser_unit.
`timescale 1ns / 1ps
`default_nettype none

package ithp_pkg;

  // Field codes carried with every result.
  typedef enum logic [4:0] {
    FLD_VERSION     = 5'd0,
    FLD_IHL         = 5'd1,
    FLD_TOS         = 5'd2,
    FLD_TOTAL_LEN   = 5'd3,
    FLD_IDENT       = 5'd4,
    FLD_FLAGS       = 5'd5,
    FLD_FRAG_OFFSET = 5'd6,
    FLD_TTL         = 5'd7,
    FLD_PROTOCOL    = 5'd8,
    FLD_IP_CSUM     = 5'd9,
    FLD_SRC_ADDR    = 5'd10,
    FLD_DST_ADDR    = 5'd11,
    FLD_SRC_PORT    = 5'd12,
    FLD_DST_PORT    = 5'd13,
    FLD_SEQ         = 5'd14,
    FLD_ACK         = 5'd15,
    FLD_DATA_OFFSET = 5'd16,
    FLD_RESERVED    = 5'd17,
    FLD_CTRL_BITS   = 5'd18,
    FLD_WINDOW      = 5'd19,
    FLD_TCP_CSUM    = 5'd20,
    FLD_URGENT_PTR  = 5'd21,
    FLD_PAYLOAD     = 5'd22
  } field_code_e;

  // Smallest legal header length in 32-bit words.
  localparam logic [3:0] MIN_HDR_WORDS = 4'd5;

  // Result queue sizing.
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // One result as it leaves the block.
  typedef struct packed {
    field_code_e code;
    logic [31:0] value;
    logic        pend;
    logic        last;
  } res_t;

  // All results caused by one byte: at most two.
  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } res_pair_t;

  // Builds a result with both end markers clear.
  function automatic res_t mk_res(field_code_e code, logic [31:0] value);
    res_t r;
    r.code  = code;
    r.value = value;
    r.pend  = 1'b0;
    r.last  = 1'b0;
    return r;
  endfunction

endpackage

`default_nettype wire

>>> sv/ithp_parse.sv
// Header parse step: per-packet state registers and the decode of one byte.
// Produces up to two results per byte as an ithp_pkg::res_pair_t.
// Depends on ithp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ithp_parse (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                step_i,
  input  wire logic [7:0]          byte_i,
  output ithp_pkg::res_pair_t      pair_o
);

  logic [15:0] pos_q;
  logic [3:0]  ihw_q, ihw_d;
  logic [15:0] plen_q, plen_d;
  logic [3:0]  thw_q, thw_d;
  logic [31:0] acc_q, acc_d;

  logic [31:0] acc_new;
  logic [3:0]  ihw_eff, thw_eff;
  logic [5:0]  ip_hdr_bytes, tcp_hdr_bytes;
  logic [15:0] tcp_pos;
  logic        pos_lt20, in_tcp, tcp_lt20, in_payload;
  logic [16:0] pos_inc;
  logic        ends, done;
  logic [1:0]  n;
  ithp_pkg::res_t r0, r1;

  // Header geometry; lengths below five words count as five.
  assign acc_new       = {acc_q[23:0], byte_i};
  assign ihw_eff       = (ihw_q < ithp_pkg::MIN_HDR_WORDS) ? ithp_pkg::MIN_HDR_WORDS : ihw_q;
  assign thw_eff       = (thw_q < ithp_pkg::MIN_HDR_WORDS) ? ithp_pkg::MIN_HDR_WORDS : thw_q;
  assign ip_hdr_bytes  = {ihw_eff, 2'b00};
  assign tcp_hdr_bytes = {thw_eff, 2'b00};
  assign pos_lt20      = pos_q < 16'd20;
  assign in_tcp        = !pos_lt20 && (pos_q >= {10'd0, ip_hdr_bytes});
  assign tcp_pos       = pos_q - {10'd0, ip_hdr_bytes};
  assign tcp_lt20      = tcp_pos < 16'd20;
  assign in_payload    = in_tcp && !tcp_lt20 && (tcp_pos >= {10'd0, tcp_hdr_bytes});
  assign pos_inc       = {1'b0, pos_q} + 17'd1;

  // Field decode for the current byte.
  always_comb begin
    r0     = ithp_pkg::mk_res(ithp_pkg::FLD_PAYLOAD, 32'd0);
    r1     = ithp_pkg::mk_res(ithp_pkg::FLD_PAYLOAD, 32'd0);
    n      = 2'd0;
    done   = 1'b0;
    ihw_d  = ihw_q;
    thw_d  = thw_q;
    plen_d = plen_q;
    acc_d  = acc_q;
    if (pos_lt20) begin
      done = 1'b1;
      unique case (pos_q[4:0])
        5'd0: begin
          ihw_d = byte_i[3:0];
          r0    = ithp_pkg::mk_res(ithp_pkg::FLD_VERSION, {28'd0, byte_i[7:4]});
          r1    = ithp_pkg::mk_res(ithp_pkg::FLD_IHL, {28'd0, byte_i[3:0]});
          n     = 2'd2;
        end
        5'd1: begin
          r0 = ithp_pkg::mk_res(ithp_pkg::FLD_TOS, {24'd0, byte_i});
          n  = 2'd1;
        end
        5'd3: begin
          plen_d = acc_new[15:0];
          r0     = ithp_pkg::mk_res(ithp_pkg::FLD_TOTAL_LEN, {16'd0, acc_new[15:0]});
          n      = 2'd1;
        end
        5'd5: begin
          r0 = ithp_pkg::mk_res(ithp_pkg::FLD_IDENT, {16'd0, acc_new[15:0]});
          n  = 2'd1;
        end
        5'd7: begin
          r0 = ithp_pkg::mk_res(ithp_pkg::FLD_FLAGS, {29'd0, acc_new[15:13]});
          r1 = ithp_pkg::mk_res(ithp_pkg::FLD_FRAG_OFFSET, {19'd0, acc_new[12:0]});
          n  = 2'd2;
        end
        5'd8: begin
          r0 = ithp_pkg::mk_res(ithp_pkg::FLD_TTL, {24'd0, byte_i});
          n  = 2'd1;
        end
        5'd9: begin
          r0 = ithp_pkg::mk_res(ithp_pkg::FLD_PROTOCOL, {24'd0, byte_i});
          n  = 2'd1;
        end
        5'd11: begin
          r0 = ithp_pkg::mk_res(ithp_pkg::FLD_IP_CSUM, {16'd0, acc_new[15:0]});
          n  = 2'd1;
        end
        5'd15: begin
          r0 = ithp_pkg::mk_res(ithp_pkg::FLD_SRC_ADDR, acc_new);
          n  = 2'd1;
        end
        5'd19: begin
          r0 = ithp_pkg::mk_res(ithp_pkg::FLD_DST_ADDR, acc_new);
          n  = 2'd1;
        end
        default: done = 1'b0;
      endcase
      acc_d = done ? 32'd0 : acc_new;
    end else if (in_tcp && tcp_lt20) begin
      done = 1'b1;
      unique case (tcp_pos[4:0])
        5'd1: begin
          r0 = ithp_pkg::mk_res(ithp_pkg::FLD_SRC_PORT, {16'd0, acc_new[15:0]});
          n  = 2'd1;
        end
        5'd3: begin
          r0 = ithp_pkg::mk_res(ithp_pkg::FLD_DST_PORT, {16'd0, acc_new[15:0]});
          n  = 2'd1;
        end
        5'd7: begin
          r0 = ithp_pkg::mk_res(ithp_pkg::FLD_SEQ, acc_new);
          n  = 2'd1;
        end
        5'd11: begin
          r0 = ithp_pkg::mk_res(ithp_pkg::FLD_ACK, acc_new);
          n  = 2'd1;
        end
        5'd12: begin
          // The data offset is reported but its byte stays in the accumulator.
          thw_d = byte_i[7:4];
          r0    = ithp_pkg::mk_res(ithp_pkg::FLD_DATA_OFFSET, {28'd0, byte_i[7:4]});
          n     = 2'd1;
          done  = 1'b0;
        end
        5'd13: begin
          r0 = ithp_pkg::mk_res(ithp_pkg::FLD_RESERVED, {26'd0, acc_new[11:6]});
          r1 = ithp_pkg::mk_res(ithp_pkg::FLD_CTRL_BITS, {26'd0, acc_new[5:0]});
          n  = 2'd2;
        end
        5'd15: begin
          r0 = ithp_pkg::mk_res(ithp_pkg::FLD_WINDOW, {16'd0, acc_new[15:0]});
          n  = 2'd1;
        end
        5'd17: begin
          r0 = ithp_pkg::mk_res(ithp_pkg::FLD_TCP_CSUM, {16'd0, acc_new[15:0]});
          n  = 2'd1;
        end
        5'd19: begin
          r0 = ithp_pkg::mk_res(ithp_pkg::FLD_URGENT_PTR, {16'd0, acc_new[15:0]});
          n  = 2'd1;
        end
        default: done = 1'b0;
      endcase
      acc_d = done ? 32'd0 : acc_new;
    end else if (in_payload) begin
      r0 = ithp_pkg::mk_res(ithp_pkg::FLD_PAYLOAD, {24'd0, byte_i});
      n  = 2'd1;
    end

    // Packet end: from byte 3 on, the byte that reaches total length.
    ends = (pos_q >= 16'd3) && (pos_inc >= {1'b0, plen_d});

    // A silent ending byte is still reported, as a payload result.
    if (ends && (n == 2'd0)) begin
      r0 = ithp_pkg::mk_res(ithp_pkg::FLD_PAYLOAD, {24'd0, byte_i});
      n  = 2'd1;
    end

    // Mark the final result of this byte.
    if (n == 2'd2) begin
      r1.pend = ends;
      r1.last = 1'b1;
    end else if (n == 2'd1) begin
      r0.pend = ends;
      r0.last = 1'b1;
    end
  end

  assign pair_o.cnt = n;
  assign pair_o.r0  = r0;
  assign pair_o.r1  = r1;

  // Per-packet state; everything returns to zero when a packet ends.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= 16'd0;
      ihw_q  <= 4'd0;
      plen_q <= 16'd0;
      thw_q  <= 4'd0;
      acc_q  <= 32'd0;
    end else if (step_i) begin
      if (ends) begin
        pos_q  <= 16'd0;
        ihw_q  <= 4'd0;
        plen_q <= 16'd0;
        thw_q  <= 4'd0;
        acc_q  <= 32'd0;
      end else begin
        pos_q  <= pos_inc[15:0];
        ihw_q  <= ihw_d;
        plen_q <= plen_d;
        thw_q  <= thw_d;
        acc_q  <= acc_d;
      end
    end
  end

endmodule

`default_nettype wire

>>> sv/ithp_res_fifo.sv
// Result queue: takes up to two results per cycle and hands out one.
// The head entry drives the block's output channel.
// Depends on ithp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ithp_res_fifo (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  push_i,
  input  ithp_pkg::res_pair_t                        pair_i,
  input  wire logic                                  pop_i,
  output logic                                       valid_o,
  output ithp_pkg::res_t                             head_o,
  output logic [ithp_pkg::FIFO_CNT_W-1:0]            count_o
);

  ithp_pkg::res_t mem_q [ithp_pkg::FIFO_DEPTH];
  logic [ithp_pkg::FIFO_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [ithp_pkg::FIFO_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [ithp_pkg::FIFO_CNT_W-1:0] cnt_q, cnt_d;
  logic [1:0]                      push_n;

  assign push_n   = push_i ? pair_i.cnt : 2'd0;
  assign wr_ptr_d = wr_ptr_q + ithp_pkg::FIFO_PTR_W'(push_n);
  assign rd_ptr_d = rd_ptr_q + ithp_pkg::FIFO_PTR_W'(pop_i);
  assign cnt_d    = cnt_q + ithp_pkg::FIFO_CNT_W'(push_n) - ithp_pkg::FIFO_CNT_W'(pop_i);

  // Result storage; entries need no reset.
  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) begin
      mem_q[wr_ptr_q] <= pair_i.r0;
    end
    if (push_n == 2'd2) begin
      mem_q[wr_ptr_q + ithp_pkg::FIFO_PTR_W'(1)] <= pair_i.r1;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  assign valid_o = cnt_q != '0;
  assign head_o  = mem_q[rd_ptr_q];
  assign count_o = cnt_q;

endmodule

`default_nettype wire

>>> sv/ipv4_tcp_header_parser_unit.sv
// IPv4/TCP header parser top level: input byte register, parse step, result queue.
// Depends on ithp_pkg, ithp_parse and ithp_res_fifo.
`timescale 1ns / 1ps
`default_nettype none

// The parser takes one raw byte per cycle from a stream of back-to-back IPv4
// packets and reports every header field once its last byte has been decoded:
// IPv4 fields first, then TCP fields, then each payload byte, with
// packet_end_o on the final result of a packet and item_last_o on the final
// result of each byte. Option bytes produce nothing unless they end the packet.
// A byte is registered on acceptance and decoded from that register into a
// four-entry result queue once the queue has room, and its results are
// presented from the queue head. The sustained rate is one byte per cycle;
// bytes 0 and 7 of the IP header and byte 13 of the TCP header yield two
// results each, and the queue absorbs these. Input stalls only when the queue
// lacks room for two results, which happens under output stall.

module ipv4_tcp_header_parser_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  data_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [4:0]       field_code_o,
  output logic [31:0]      field_value_o,
  output logic             packet_end_o,
  output logic             item_last_o
);

  logic                                vld_q;
  logic [7:0]                          byte_q;
  logic                                step, room, pop;
  logic [ithp_pkg::FIFO_CNT_W-1:0]     fifo_cnt;
  ithp_pkg::res_pair_t                 pair;
  ithp_pkg::res_t                      head;

  // The queue must hold both possible results of the registered byte.
  assign pop  = out_valid_o && !out_stall_i;
  assign room = {1'b0, fifo_cnt} <=
                ((ithp_pkg::FIFO_CNT_W + 1)'(ithp_pkg::FIFO_DEPTH - 2) +
                 (ithp_pkg::FIFO_CNT_W + 1)'(pop));
  assign step = vld_q && room;
  assign in_stall_o = vld_q && !room;

  // Input byte register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      byte_q <= data_byte_i;
    end
  end

  ithp_parse u_parse (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .byte_i (byte_q),
    .pair_o (pair)
  );

  ithp_res_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (step),
    .pair_i  (pair),
    .pop_i   (pop),
    .valid_o (out_valid_o),
    .head_o  (head),
    .count_o (fifo_cnt)
  );

  // Output transaction fields come from the queue head.
  assign field_code_o  = head.code;
  assign field_value_o = head.value;
  assign packet_end_o  = head.pend;
  assign item_last_o   = head.last;

  // The queue never overfills.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, fifo_cnt} <= (ithp_pkg::FIFO_CNT_W + 1)'(ithp_pkg::FIFO_DEPTH))
    else $error("result queue overflow");

  // A stalled byte stays in the input register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q && !room) |=> (vld_q && $stable(byte_q)))
    else $error("registered byte lost while stalled");

  // Exactly the final result of a step carries the byte-end marker.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && (pair.cnt == 2'd2)) |-> (pair.r1.last && !pair.r0.last && !pair.r0.pend))
    else $error("two-result step marked wrongly");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && (pair.cnt != 2'd2)) |-> ((pair.cnt == 2'd0) || pair.r0.last))
    else $error("single-result step not marked last");

  // A packet ends only on the last result of a byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && packet_end_o) |-> item_last_o)
    else $error("packet end without byte end");

endmodule

`default_nettype wire

>>> bench/tb_ipv4_tcp_header_parser_unit.sv
// Self-checking testbench for ipv4_tcp_header_parser_unit: streams IPv4/TCP packets
// byte by byte and compares every reported field with an internal parser model.
// Depends on ithp_pkg and the parser RTL.
`timescale 1ns / 1ps

module tb_ipv4_tcp_header_parser_unit;

  localparam int QUIET_LIMIT = 5000;
  localparam int HOLD_CYCLES = 200;
  localparam int RANDOM_BYTES = 2000;
  localparam int TAIL_BYTES = 64;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic [7:0]  data_byte = 8'd0;
  logic        out_stall = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic [4:0]  field_code;
  logic [31:0] field_value;
  logic        packet_end;
  logic        item_last;

  // Byte stream still to be offered, and fields the parser still owes us.
  logic [7:0]     pending_bytes [$];
  ithp_pkg::res_t owed_fields [$];

  // Parser model state.
  logic [15:0] pos_q = '0;
  logic [3:0]  ihl_q = '0;
  logic [15:0] len_q = '0;
  logic [3:0]  tcp_words_q = '0;
  logic [31:0] acc_q = '0;

  int   in_count = 0;
  int   n_small = 0;
  int   hold_at = 0;
  int   hold_left = 0;
  logic hold_done = 1'b0;
  int   errors = 0;
  int   quiet = 0;
  int   phase;
  int   send_pct;
  int   recv_pct;
  ithp_pkg::res_t want;

  ipv4_tcp_header_parser_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .data_byte_i   (data_byte),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .field_code_o  (field_code),
    .field_value_o (field_value),
    .packet_end_o  (packet_end),
    .item_last_o   (item_last)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Idle mix: sender light / receiver heavy, then swapped, then no idling.
  assign phase    = (in_count < n_small / 3) ? 0 : (in_count < 2 * n_small / 3) ? 1 : 2;
  assign send_pct = (phase == 0) ? 14 : (phase == 1) ? 72 : 0;
  assign recv_pct = (phase == 0) ? 72 : (phase == 1) ? 14 : 0;

  // Header length in bytes; word counts below the minimum count as the minimum.
  function automatic int hdr_len(logic [3:0] words);
    return 4 * ((words < ithp_pkg::MIN_HDR_WORDS) ? int'(ithp_pkg::MIN_HDR_WORDS)
                                                  : int'(words));
  endfunction

  function automatic ithp_pkg::res_t field_result(ithp_pkg::field_code_e code,
                                                  logic [31:0] value);
    ithp_pkg::res_t r;
    r.code  = code;
    r.value = value;
    r.pend  = 1'b0;
    r.last  = 1'b0;
    return r;
  endfunction

  // Advances the parser model by one byte and queues the fields it completes.
  task automatic predict_byte(input logic [7:0] b);
    ithp_pkg::res_t r [0:1];
    int             n;
    int             iph;
    int             t;
    logic [31:0]    nacc;
    logic           done;
    n    = 0;
    nacc = {acc_q[23:0], b};
    done = 1'b0;
    if (pos_q < 20) begin
      // Fixed IPv4 header.
      done = 1'b1;
      case (pos_q)
        0: begin
          ihl_q = b[3:0];
          r[0] = field_result(ithp_pkg::FLD_VERSION, {28'd0, b[7:4]});
          r[1] = field_result(ithp_pkg::FLD_IHL, {28'd0, b[3:0]});
          n = 2;
        end
        1: begin r[0] = field_result(ithp_pkg::FLD_TOS, {24'd0, b}); n = 1; end
        3: begin
          len_q = nacc[15:0];
          r[0] = field_result(ithp_pkg::FLD_TOTAL_LEN, {16'd0, nacc[15:0]});
          n = 1;
        end
        5: begin r[0] = field_result(ithp_pkg::FLD_IDENT, {16'd0, nacc[15:0]}); n = 1; end
        7: begin
          r[0] = field_result(ithp_pkg::FLD_FLAGS, {29'd0, nacc[15:13]});
          r[1] = field_result(ithp_pkg::FLD_FRAG_OFFSET, {19'd0, nacc[12:0]});
          n = 2;
        end
        8: begin r[0] = field_result(ithp_pkg::FLD_TTL, {24'd0, b}); n = 1; end
        9: begin r[0] = field_result(ithp_pkg::FLD_PROTOCOL, {24'd0, b}); n = 1; end
        11: begin
          r[0] = field_result(ithp_pkg::FLD_IP_CSUM, {16'd0, nacc[15:0]});
          n = 1;
        end
        15: begin r[0] = field_result(ithp_pkg::FLD_SRC_ADDR, nacc); n = 1; end
        19: begin r[0] = field_result(ithp_pkg::FLD_DST_ADDR, nacc); n = 1; end
        default: done = 1'b0;
      endcase
      acc_q = done ? 32'd0 : nacc;
    end else begin
      iph = hdr_len(ihl_q);
      if (int'(pos_q) >= iph) begin
        t = int'(pos_q) - iph;
        if (t < 20) begin
          // Fixed TCP header.
          done = 1'b1;
          case (t)
            1: begin
              r[0] = field_result(ithp_pkg::FLD_SRC_PORT, {16'd0, nacc[15:0]});
              n = 1;
            end
            3: begin
              r[0] = field_result(ithp_pkg::FLD_DST_PORT, {16'd0, nacc[15:0]});
              n = 1;
            end
            7: begin r[0] = field_result(ithp_pkg::FLD_SEQ, nacc); n = 1; end
            11: begin r[0] = field_result(ithp_pkg::FLD_ACK, nacc); n = 1; end
            12: begin
              // Data offset is reported early but stays in the accumulator.
              tcp_words_q = b[7:4];
              r[0] = field_result(ithp_pkg::FLD_DATA_OFFSET, {28'd0, b[7:4]});
              n = 1;
              done = 1'b0;
            end
            13: begin
              r[0] = field_result(ithp_pkg::FLD_RESERVED, {26'd0, nacc[11:6]});
              r[1] = field_result(ithp_pkg::FLD_CTRL_BITS, {26'd0, nacc[5:0]});
              n = 2;
            end
            15: begin
              r[0] = field_result(ithp_pkg::FLD_WINDOW, {16'd0, nacc[15:0]});
              n = 1;
            end
            17: begin
              r[0] = field_result(ithp_pkg::FLD_TCP_CSUM, {16'd0, nacc[15:0]});
              n = 1;
            end
            19: begin
              r[0] = field_result(ithp_pkg::FLD_URGENT_PTR, {16'd0, nacc[15:0]});
              n = 1;
            end
            default: done = 1'b0;
          endcase
          acc_q = done ? 32'd0 : nacc;
        end else if (t >= hdr_len(tcp_words_q)) begin
          r[0] = field_result(ithp_pkg::FLD_PAYLOAD, {24'd0, b});
          n = 1;
        end
      end
    end
    // Total length reached: a byte that completes nothing is reported as payload.
    if (pos_q >= 3 && int'(pos_q) + 1 >= int'(len_q)) begin
      if (n == 0) begin
        r[0] = field_result(ithp_pkg::FLD_PAYLOAD, {24'd0, b});
        n = 1;
      end
      r[n - 1].pend = 1'b1;
      pos_q = '0;
      ihl_q = '0;
      len_q = '0;
      tcp_words_q = '0;
      acc_q = '0;
    end else begin
      pos_q = pos_q + 16'd1;
    end
    if (n > 0) r[n - 1].last = 1'b1;
    for (int i = 0; i < n; i++) owed_fields = {owed_fields, r[i]};
  endtask

  // Queues one packet with the given header sizes and total length field.
  task automatic push_packet(input logic [3:0] ihl, input logic [3:0] doff, input int tot_len);
    logic [15:0] len;
    logic [7:0]  b;
    int          tcp_at;
    int          count;
    len    = tot_len[15:0];
    tcp_at = hdr_len(ihl) + 12;
    count  = (tot_len <= 4) ? 4 : tot_len;
    for (int i = 0; i < count; i++) begin
      b = 8'($urandom);
      if (i == 0) b = {($urandom_range(9) == 0) ? 4'($urandom) : 4'd4, ihl};
      else if (i == 2) b = len[15:8];
      else if (i == 3) b = len[7:0];
      else if (i == tcp_at) b[7:4] = doff;
      pending_bytes = {pending_bytes, b};
    end
  endtask

  // Driver: offers bytes and runs the model on each accepted transaction.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid  <= 1'b0;
      data_byte <= 8'd0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_byte(data_byte);
        in_count <= in_count + 1;
      end
      if (!(in_valid && in_stall)) begin
        if (pending_bytes.size() != 0 && $urandom_range(99) >= send_pct) begin
          in_valid  <= 1'b1;
          data_byte <= pending_bytes.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted result and drives the receiver stall.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (owed_fields.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected result: code %0d value %h end %b last %b",
                     field_code, field_value, packet_end, item_last);
        end else begin
          want = owed_fields.pop_front();
          if (field_code !== want.code || field_value !== want.value ||
              packet_end !== want.pend || item_last !== want.last) begin
            errors++;
            if (errors <= 10)
              $display({"mismatch: got code %0d value %h end %b last %b, ",
                        "want code %0d value %h end %b last %b"},
                       field_code, field_value, packet_end, item_last,
                       want.code, want.value, want.pend, want.last);
          end
        end
      end
      // One long hold-off while the sender keeps going, otherwise random stalls.
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left <= hold_left - 1;
      end else if (!hold_done && n_small != 0 && in_count >= hold_at) begin
        out_stall <= 1'b1;
        hold_left <= HOLD_CYCLES - 1;
        hold_done <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_pct);
      end
    end
  end

  // Watchdog on cycles with no transaction on either side.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet <= 0;
      end else if (quiet >= QUIET_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end else begin
        quiet <= quiet + 1;
      end
    end
  end

  initial begin
    int          kind;
    logic [3:0]  ihl;
    logic [3:0]  doff;
    int          full;
    // Short packets: zero length, length four ending on byte 3, a silent
    // end inside the flags word, and an end on the two-field byte.
    pending_bytes = {8'h45, 8'h00, 8'h00, 8'h00,
                     8'hFF, 8'hFF, 8'h00, 8'h04,
                     8'h45, 8'h00, 8'h00, 8'h07, 8'h12, 8'h34, 8'hAB,
                     8'h45, 8'h00, 8'h00, 8'h08, 8'h00, 8'h00, 8'hFF, 8'hFF};
    // Random packets, mostly well formed.
    while (pending_bytes.size() < RANDOM_BYTES) begin
      kind = $urandom_range(99);
      if (kind < 60) begin
        ihl  = ($urandom_range(3) == 0) ? 4'($urandom_range(6, 15)) : 4'd5;
        doff = ($urandom_range(3) == 0) ? 4'($urandom_range(6, 15)) : 4'd5;
      end else begin
        ihl  = 4'($urandom);
        doff = 4'($urandom);
      end
      full = hdr_len(ihl) + hdr_len(doff) + $urandom_range(0, 24);
      if (kind < 75) push_packet(ihl, doff, full);
      else if (kind < 90) push_packet(ihl, doff, $urandom_range(0, full));
      else push_packet(ihl, doff, $urandom_range(0, 300));
    end
    n_small = pending_bytes.size();
    hold_at = 2 * n_small / 3 + 40;
    // The start of one packet near the largest total length; only its head is sent.
    push_packet(4'd5, 4'd5, 32'hFC00 + $urandom_range(0, 1023));
    while (pending_bytes.size() > n_small + TAIL_BYTES)
      void'(pending_bytes.pop_back());

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_bytes.size() != 0 || in_valid || owed_fields.size() != 0)
      @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    errors += owed_fields.size();
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
sv/ithp_pkg.sv
sv/ithp_parse.sv
sv/ithp_res_fifo.sv
sv/ipv4_tcp_header_parser_unit.sv
bench/tb_ipv4_tcp_header_parser_unit.sv
